>>> sv/fcrc_pkg.sv
// Package: shared types and constants of the free cluster run coalescer.
package fcrc_pkg;

	localparam int LBA_W        = 32;
	localparam int ENTRY_W      = 32;
	localparam int ENTRY_MASK_W = 28;
	localparam int SPC_W        = 8;
	localparam int CFG_IDX_W    = 1;
	localparam int CFG_DATA_W   = 32;
	localparam int RESULT_DEPTH = 4;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_DATA_START = 1'b0,
		CFG_SPC        = 1'b1
	} cfg_reg_t;

	typedef enum logic {
		KIND_ERASE = 1'b0,
		KIND_ABORT = 1'b1
	} result_kind_t;

	typedef struct packed {
		logic [ENTRY_W-1:0] table_entry;
		logic               end_of_table;
		logic               read_failed;
	} item_t;

	typedef struct packed {
		result_kind_t     kind;
		logic [LBA_W-1:0] first_lba;
		logic [LBA_W-1:0] last_lba;
		logic             last_of_run;
	} result_t;

	typedef struct packed {
		logic [LBA_W-1:0] cluster_index;
		logic             run_open;
		logic [LBA_W-1:0] run_first_lba;
		logic [LBA_W-1:0] run_last_lba;
	} scan_state_t;

endpackage

>>> sv/fcrc_item_if.sv
// Interface: input item channel (valid/ready plus allocation entry fields).
interface fcrc_item_if;
	import fcrc_pkg::*;

	logic               valid;
	logic               ready;
	logic [ENTRY_W-1:0] table_entry;
	logic               end_of_table;
	logic               read_failed;

	modport source(output valid, output table_entry, output end_of_table,
		output read_failed, input ready);
	modport sink(input valid, input table_entry, input end_of_table,
		input read_failed, output ready);
endinterface

>>> sv/fcrc_result_if.sv
// Interface: result channel (valid/ready plus erase request fields).
interface fcrc_result_if;
	import fcrc_pkg::*;

	logic             valid;
	logic             ready;
	logic             result_kind;
	logic [LBA_W-1:0] erase_first_lba;
	logic [LBA_W-1:0] erase_last_lba;
	logic             last_of_run;

	modport source(output valid, output result_kind, output erase_first_lba,
		output erase_last_lba, output last_of_run, input ready);
	modport sink(input valid, input result_kind, input erase_first_lba,
		input erase_last_lba, input last_of_run, output ready);
endinterface

>>> sv/fcrc_cfg_if.sv
// Interface: configuration write channel (valid/ready, register index, data).
interface fcrc_cfg_if;
	import fcrc_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source(output valid, output index, output data, input ready);
	modport sink(input valid, input index, input data, output ready);
endinterface

>>> sv/fcrc_step.sv
// Per-entry scan logic: next scan state and up to two erase/abort results.
module fcrc_step (
	input  fcrc_pkg::item_t                  item,
	input  fcrc_pkg::scan_state_t            cur,
	input  logic [fcrc_pkg::LBA_W-1:0]       data_start_lba,
	input  logic [fcrc_pkg::SPC_W-1:0]       sectors_per_cluster,
	output fcrc_pkg::scan_state_t            nxt,
	output fcrc_pkg::result_t                res0,
	output fcrc_pkg::result_t                res1,
	output logic [1:0]                       res_cnt
);
	import fcrc_pkg::*;

	logic [SPC_W-1:0]       spc;
	logic [LBA_W-1:0]       idx_m2;
	logic [LBA_W+SPC_W-1:0] prod;
	logic [LBA_W-1:0]       lo;
	logic [LBA_W-1:0]       hi;
	logic                   reserved;
	logic                   is_free;
	logic                   extend;
	logic                   new_run;
	logic                   close_a;
	logic                   close_b;
	logic                   open1;
	logic [LBA_W-1:0]       first1;
	logic [LBA_W-1:0]       last1;
	result_t                ra;
	result_t                rb;

	assign spc      = (sectors_per_cluster == '0) ? SPC_W'(1) : sectors_per_cluster;
	assign idx_m2   = cur.cluster_index - LBA_W'(2);
	assign prod     = idx_m2 * spc;
	assign lo       = data_start_lba + prod[LBA_W-1:0];
	assign hi       = lo + LBA_W'(spc) - LBA_W'(1);
	assign reserved = (cur.cluster_index < LBA_W'(2));
	assign is_free  = (item.table_entry[ENTRY_MASK_W-1:0] == '0);

	assign extend  = !reserved && is_free && cur.run_open && (lo == cur.run_last_lba + LBA_W'(1));
	assign new_run = !reserved && is_free && !extend;
	assign close_a = cur.run_open && !extend;
	assign open1   = extend || new_run;
	assign first1  = new_run ? lo : cur.run_first_lba;
	assign last1   = open1 ? hi : cur.run_last_lba;
	assign close_b = item.end_of_table && open1;

	always_comb begin
		ra             = '0;
		ra.kind        = KIND_ERASE;
		ra.first_lba   = cur.run_first_lba;
		ra.last_lba    = cur.run_last_lba;
		ra.last_of_run = !close_b;
		rb             = '0;
		rb.kind        = KIND_ERASE;
		rb.first_lba   = first1;
		rb.last_lba    = last1;
		rb.last_of_run = 1'b1;

		if (item.read_failed) begin
			nxt              = '0;
			res0             = '0;
			res0.kind        = KIND_ABORT;
			res0.last_of_run = 1'b1;
			res1             = rb;
			res_cnt          = 2'd1;
		end else begin
			nxt.run_first_lba = first1;
			nxt.run_last_lba  = last1;
			if (item.end_of_table) begin
				nxt.cluster_index = '0;
				nxt.run_open      = 1'b0;
			end else begin
				nxt.cluster_index = cur.cluster_index + LBA_W'(1);
				nxt.run_open      = open1;
			end
			res0    = close_a ? ra : rb;
			res1    = rb;
			res_cnt = {1'b0, close_a} + {1'b0, close_b};
		end
	end
endmodule

>>> sv/fcrc_rq.sv
// Result queue: takes up to two results per cycle, hands out one per cycle.
module fcrc_rq #(
	parameter int DEPTH = fcrc_pkg::RESULT_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  fcrc_pkg::result_t push0,
	input  fcrc_pkg::result_t push1,
	input  logic [1:0]        push_cnt,
	input  logic              pop,
	output fcrc_pkg::result_t head,
	output logic              not_empty,
	output logic              room2
);
	import fcrc_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	result_t       mem_q [DEPTH];
	logic [PW-1:0] wr_q;
	logic [PW-1:0] rd_q;
	logic [CW-1:0] cnt_q;
	logic [PW-1:0] wr_p1;
	logic [PW-1:0] wr_p2;
	logic [PW-1:0] rd_p1;

	function automatic logic [PW-1:0] inc(input logic [PW-1:0] p);
		return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
	endfunction

	assign wr_p1     = inc(wr_q);
	assign wr_p2     = inc(wr_p1);
	assign rd_p1     = inc(rd_q);
	assign head      = mem_q[rd_q];
	assign not_empty = (cnt_q != '0);
	assign room2     = (cnt_q <= CW'(DEPTH - 2));

	always_ff @(posedge clk) begin
		if (push_cnt != 2'd0) begin
			mem_q[wr_q] <= push0;
		end
		if (push_cnt == 2'd2) begin
			mem_q[wr_p1] <= push1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			case (push_cnt)
				2'd1:    wr_q <= wr_p1;
				2'd2:    wr_q <= wr_p2;
				default: wr_q <= wr_q;
			endcase
			if (pop) begin
				rd_q <= rd_p1;
			end
			cnt_q <= cnt_q + CW'(push_cnt) - CW'(pop);
		end
	end
endmodule

>>> sv/free_cluster_run_coalescer.sv
// Top level: free cluster run coalescer (allocation table scan to erase ranges).
// Flow: an accepted entry is held in item_s1, evaluated by fcrc_step and, once the
// result queue has room for two results, its results are written into the queue and
// offered from its head. Throughput: one entry per cycle while the queue has room
// for two results; the single result port drains the queue one result at a time.
// Reset: scan state, run and queue cleared; data_start_lba = 0, sectors/cluster = 1.
module free_cluster_run_coalescer #(
	parameter int RESULT_DEPTH = fcrc_pkg::RESULT_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	fcrc_item_if.sink   items,
	fcrc_result_if.source results,
	fcrc_cfg_if.sink    cfg
);
	import fcrc_pkg::*;

	logic                   s1_valid_q;
	item_t                  item_s1;
	scan_state_t            state_q;
	scan_state_t            state_nxt;
	logic [LBA_W-1:0]       data_start_q;
	logic [SPC_W-1:0]       spc_q;
	result_t                res0;
	result_t                res1;
	result_t                head;
	logic [1:0]             res_cnt;
	logic                   room2;
	logic                   not_empty;
	logic                   fire;
	logic                   take;

	assign fire        = s1_valid_q && room2;
	assign items.ready = !s1_valid_q || fire;
	assign take        = items.valid && items.ready;
	assign cfg.ready   = 1'b1;

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1.table_entry  <= items.table_entry;
			item_s1.end_of_table <= items.end_of_table;
			item_s1.read_failed  <= items.read_failed;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q   <= 1'b0;
			state_q      <= '0;
			data_start_q <= '0;
			spc_q        <= SPC_W'(1);
		end else begin
			if (take) begin
				s1_valid_q <= 1'b1;
			end else if (fire) begin
				s1_valid_q <= 1'b0;
			end
			if (fire) begin
				state_q <= state_nxt;
			end
			if (cfg.valid) begin
				case (cfg_reg_t'(cfg.index))
					CFG_DATA_START: data_start_q <= cfg.data[LBA_W-1:0];
					CFG_SPC:        spc_q        <= cfg.data[SPC_W-1:0];
					default:        spc_q        <= spc_q;
				endcase
			end
		end
	end

	fcrc_step u_step (
		.item                (item_s1),
		.cur                 (state_q),
		.data_start_lba      (data_start_q),
		.sectors_per_cluster (spc_q),
		.nxt                 (state_nxt),
		.res0                (res0),
		.res1                (res1),
		.res_cnt             (res_cnt)
	);

	fcrc_rq #(
		.DEPTH (RESULT_DEPTH)
	) u_rq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push0     (res0),
		.push1     (res1),
		.push_cnt  (fire ? res_cnt : 2'd0),
		.pop       (results.valid && results.ready),
		.head      (head),
		.not_empty (not_empty),
		.room2     (room2)
	);

	assign results.valid           = not_empty;
	assign results.result_kind     = head.kind;
	assign results.erase_first_lba = head.first_lba;
	assign results.erase_last_lba  = head.last_lba;
	assign results.last_of_run     = head.last_of_run;
endmodule
